@@ src/rsled_pkg.sv @@
`timescale 1ns / 1ps

package rsled_pkg;

  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 32;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] REG_COMMON_ANODE   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_BLINK_INTERVAL = 2'd1;

  localparam logic        CommonAnodeReset   = 1'b1;
  localparam logic [15:0] BlinkIntervalReset = 16'd250;

  localparam logic [10:0] ScanPeriodLast    = 11'd1999;
  localparam logic [10:0] ScanHalf          = 11'd1000;
  localparam logic [10:0] ConnectPeriodLast = 11'd1599;
  localparam logic [10:0] ConnectHalf       = 11'd800;

  // Reciprocal multipliers: floor(q * 235 / 1000) and floor(q * 170 / 800).
  localparam logic [35:0] ScanMul    = 36'd63082460;
  localparam logic [34:0] ConnectMul = 35'd28521410;

  localparam logic [7:0] ScanLow     = 8'd20;
  localparam logic [7:0] LevelFull   = 8'd255;
  localparam logic [7:0] ConnectLow  = 8'd30;
  localparam logic [7:0] ConnectHigh = 8'd200;
  localparam logic [7:0] ConnectBlue = 8'd40;
  localparam logic [7:0] LevelAmber  = 8'd120;
  localparam logic [7:0] LevelSixty  = 8'd60;
  localparam logic [7:0] LevelTwenty = 8'd20;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_MODE = 2'd1,
    CMD_FLASH    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_SCANNING = 3'd0,
    MODE_CONNECTED = 3'd1,
    MODE_DISARMED = 3'd2,
    MODE_ALERT    = 3'd3,
    MODE_IDLE     = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration;
  } item_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
    logic       flash_active;
  } result_t;

  function automatic rgb_t fixed_color(mode_t m);
    rgb_t c;
    c = '0;
    unique case (m)
      MODE_CONNECTED: c = '{red: 8'd0, green: LevelSixty, blue: LevelTwenty};
      MODE_DISARMED:  c = '{red: LevelAmber, green: LevelSixty, blue: 8'd0};
      MODE_ALERT:     c = '{red: LevelFull, green: 8'd0, blue: 8'd0};
      default:        c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] scan_level(logic [10:0] p);
    logic        rising;
    logic [9:0]  q;
    logic [35:0] prod;
    logic [7:0]  part;
    rising = (p < ScanHalf);
    q      = rising ? p[9:0] : 10'(p - ScanHalf);
    prod   = 36'(q) * ScanMul;
    part   = prod[35:28];
    return rising ? (ScanLow + part) : (LevelFull - part);
  endfunction

  function automatic logic [7:0] connect_level(logic [10:0] p);
    logic        rising;
    logic [9:0]  q;
    logic [34:0] prod;
    logic [7:0]  part;
    rising = (p < ConnectHalf);
    q      = rising ? p[9:0] : 10'(p - ConnectHalf);
    prod   = 35'(q) * ConnectMul;
    part   = prod[34:27];
    return rising ? (ConnectLow + part) : (ConnectHigh - part);
  endfunction

endpackage

@@ src/rgb_status_led_pattern_generator_top.sv @@
`timescale 1ns / 1ps
// An input transfer is captured in the input register; its result is computed from there and
// loaded into the output register once that register is empty or drained, then transferred.
// Throughput: one item per cycle; the input register and the output register form a
// two-stage pipeline that advances whenever the output register is empty or drained.
// Reset (rst, synchronous, active high) clears the mode to scanning, all counters,
// the shown colour and the flash, and sets common_anode to 1 and blink_interval to 250.

module rgb_status_led_pattern_generator_top
  import rsled_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // command[1:0], mode[4:2], red[12:5], green[20:13], blue[28:21], duration[44:29]
  input  logic [InDataWidth-1:0]  s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // red_duty[7:0], green_duty[15:8], blue_duty[23:16], flash_active[24]
  output logic [OutDataWidth-1:0] m_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  logic        common_anode;
  logic [15:0] blink_interval;
  logic        in_valid;
  item_t       in_item;
  logic        out_load;
  result_t     result;
  result_t     out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode   <= CommonAnodeReset;
      blink_interval <= BlinkIntervalReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COMMON_ANODE) begin
        common_anode <= cfg_data[0];
      end else if (cfg_index == REG_BLINK_INTERVAL) begin
        blink_interval <= cfg_data;
      end
    end
  end

  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command  <= s_tdata[1:0];
      in_item.mode     <= s_tdata[4:2];
      in_item.red      <= s_tdata[12:5];
      in_item.green    <= s_tdata[20:13];
      in_item.blue     <= s_tdata[28:21];
      in_item.duration <= s_tdata[44:29];
    end
  end

  rsled_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (out_load),
    .item           (in_item),
    .common_anode   (common_anode),
    .blink_interval (blink_interval),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'd0, out_result.flash_active, out_result.blue_duty,
                    out_result.green_duty, out_result.red_duty};

endmodule

@@ src/rsled_core.sv @@
`timescale 1ns / 1ps

module rsled_core
  import rsled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic        common_anode,
  input  logic [15:0] blink_interval,
  output result_t     result
);

  mode_t       current_mode, current_mode_next;
  logic [10:0] scan_phase, scan_phase_next;
  logic [10:0] connect_phase, connect_phase_next;
  logic [15:0] blink_elapsed, blink_elapsed_next;
  logic        alert_lit, alert_lit_next;
  rgb_t        latched, latched_next;
  logic [15:0] flash_left, flash_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode  <= MODE_SCANNING;
      scan_phase    <= '0;
      connect_phase <= '0;
      blink_elapsed <= '0;
      alert_lit     <= 1'b0;
      latched       <= '0;
      flash_left    <= '0;
    end else if (fire) begin
      current_mode  <= current_mode_next;
      scan_phase    <= scan_phase_next;
      connect_phase <= connect_phase_next;
      blink_elapsed <= blink_elapsed_next;
      alert_lit     <= alert_lit_next;
      latched       <= latched_next;
      flash_left    <= flash_left_next;
    end
  end

  always_comb begin
    current_mode_next  = current_mode;
    scan_phase_next    = scan_phase;
    connect_phase_next = connect_phase;
    blink_elapsed_next = blink_elapsed;
    alert_lit_next     = alert_lit;
    latched_next       = latched;
    flash_left_next    = flash_left;

    unique case (cmd_t'(item.command))
      CMD_TICK: begin
        scan_phase_next    = (scan_phase == ScanPeriodLast) ? '0 : scan_phase + 11'd1;
        connect_phase_next = (connect_phase == ConnectPeriodLast) ? '0
                                                                  : connect_phase + 11'd1;
        if (blink_elapsed != 16'hFFFF) begin
          blink_elapsed_next = blink_elapsed + 16'd1;
        end
        if (flash_left != '0) begin
          flash_left_next = flash_left - 16'd1;
          if (flash_left == 16'd1) begin
            latched_next = fixed_color(current_mode);
          end
        end else begin
          unique case (current_mode)
            MODE_SCANNING: begin
              latched_next = '{red: scan_level(scan_phase_next), green: 8'd0, blue: 8'd0};
            end
            MODE_CONNECTED: begin
              latched_next = '{red: 8'd0, green: connect_level(connect_phase_next),
                               blue: ConnectBlue};
            end
            MODE_ALERT: begin
              if (blink_elapsed_next >= blink_interval) begin
                alert_lit_next     = ~alert_lit;
                latched_next       = '{red: alert_lit ? 8'd0 : LevelFull,
                                       green: 8'd0, blue: 8'd0};
                blink_elapsed_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CMD_SET_MODE: begin
        if (item.mode <= MODE_IDLE) begin
          current_mode_next = mode_t'(item.mode);
          if (item.mode != current_mode) begin
            alert_lit_next     = 1'b0;
            blink_elapsed_next = '0;
          end
          if (flash_left == '0) begin
            latched_next = fixed_color(mode_t'(item.mode));
          end
        end
      end
      CMD_FLASH: begin
        flash_left_next = item.duration;
        if (item.duration == '0) begin
          latched_next = fixed_color(current_mode);
        end else begin
          latched_next = '{red: item.red, green: item.green, blue: item.blue};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (common_anode) begin
      result.red_duty   = LevelFull - latched_next.red;
      result.green_duty = LevelFull - latched_next.green;
      result.blue_duty  = LevelFull - latched_next.blue;
    end else begin
      result.red_duty   = latched_next.red;
      result.green_duty = latched_next.green;
      result.blue_duty  = latched_next.blue;
    end
    result.flash_active = (flash_left_next != '0);
  end

endmodule
